// ===== src/pps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants of the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int MAX_PROCESSES = 16;
  localparam int IDX_W         = $clog2(MAX_PROCESSES);
  localparam int CNT_W         = 5;

  // Item operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // One process table entry
  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
    logic [15:0] remaining;
  } entry_t;

  // Table write request
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } tbl_wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

endpackage

// ===== src/pps_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_in_if
// Input item channel: load and tick items.
// ----------------------------------------------------------------------------
interface pps_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [3:0]  slot;
  logic [15:0] arrival_time;
  logic [15:0] burst_time;
  logic [7:0]  priority_req;

  modport source (output valid, op, slot, arrival_time, burst_time, priority_req,
                  input ready);
  modport sink   (input valid, op, slot, arrival_time, burst_time, priority_req,
                  output ready);
endinterface

// ===== src/pps_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_out_if
// Result channel: one result per tick item.
// ----------------------------------------------------------------------------
interface pps_out_if;
  logic        valid;
  logic        ready;
  logic        ran;
  logic [3:0]  process_id;
  logic        finished;
  logic [31:0] turnaround;
  logic [31:0] waiting;
  logic        all_done;
  logic [31:0] current_time;

  modport source (output valid, ran, process_id, finished, turnaround, waiting,
                  all_done, current_time, input ready);
  modport sink   (input valid, ran, process_id, finished, turnaround, waiting,
                  all_done, current_time, output ready);
endinterface

// ===== src/pps_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_cfg_if
// Configuration write channel for the process count register.
// ----------------------------------------------------------------------------
interface pps_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== src/preemptive_priority_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Priority scheduler over a process table held in a synchronous memory.
// ----------------------------------------------------------------------------
//  channel   direction  transfer carries
//  in_ch     in         op, slot, arrival_time, burst_time, priority_req
//  out_ch    out        ran, process_id, finished, turnaround, waiting,
//                       all_done, current_time (one per tick)
//  cfg_ch    in         process_count (5 bits), always ready
//
// A load is written to the table as it is accepted. A tick goes through accept,
// a scan with one table read per slot in use through the single read port,
// then write-back of the chosen entry with the result.
// Reset clears time and completion count, sets process count to 1; the table
// holds nothing defined until loaded. A stalled result holds in the output
// register; the next item is taken meanwhile and its tick waits at write-back.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler (
  input  logic clk,
  input  logic rst_n,
  pps_in_if.sink    in_ch,
  pps_out_if.source out_ch,
  pps_cfg_if.sink   cfg_ch
);
  import pps_pkg::*;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r;
  logic             found_r;
  logic [7:0]       best_r;
  logic [IDX_W-1:0] pick_r;
  logic [15:0]      pick_arr_r, pick_burst_r, pick_rem_r;
  logic [CNT_W-1:0] nz_cnt_r;
  logic [31:0]      time_r;
  logic [CNT_W-1:0] done_cnt_r;
  logic [CNT_W-1:0] pcount_r;

  logic             out_valid_r;
  logic             out_ran_r, out_fin_r, out_all_r;
  logic [3:0]       out_pid_r;
  logic [31:0]      out_tat_r, out_wt_r, out_time_r;

  tbl_wr_t          wr;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;

  logic             in_xfer, tick_xfer;
  logic [CNT_W-1:0] n_slots;
  logic             last_slot, eligible, take, adv;
  logic [31:0]      time_inc, tat, wt;
  logic             fin, all_done;

  pps_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Slots in use, clamped to the table depth
  assign n_slots = (pcount_r > CNT_W'(MAX_PROCESSES)) ? CNT_W'(MAX_PROCESSES) : pcount_r;

  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign tick_xfer = in_xfer && (in_ch.op == OP_TICK);

  // Scan compare on the entry read this cycle
  assign last_slot = ({1'b0, idx_r} == (n_slots - CNT_W'(1)));
  assign eligible  = ({16'd0, rd_data.arrival} <= time_r) && (rd_data.remaining != 16'd0);
  assign take      = eligible && (!found_r || (rd_data.prio < best_r));

  // Write-back results
  assign adv      = !out_valid_r || out_ch.ready;
  assign time_inc = time_r + 32'd1;
  assign fin      = found_r && (pick_rem_r == 16'd1);
  assign tat      = time_inc - {16'd0, pick_arr_r};
  assign wt       = tat - {16'd0, pick_burst_r};
  assign all_done = (nz_cnt_r == '0) || ((nz_cnt_r == CNT_W'(1)) && fin);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (tick_xfer) begin
          state_nxt = (n_slots == '0) ? ST_WRITE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_slot) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (adv) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake, read address and table write
  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
    rd_addr     = (state_r == ST_IDLE) ? '0 : idx_r + IDX_W'(1);
    wr          = '0;
    unique case (state_r)
      ST_IDLE: begin
        wr.en             = in_xfer && (in_ch.op == OP_LOAD) &&
                            ({1'b0, in_ch.slot} < 5'(MAX_PROCESSES));
        wr.addr           = IDX_W'(in_ch.slot);
        wr.data.arrival   = in_ch.arrival_time;
        wr.data.burst     = in_ch.burst_time;
        wr.data.prio      = in_ch.priority_req;
        wr.data.remaining = in_ch.burst_time;
      end
      ST_WRITE: begin
        wr.en             = adv && found_r;
        wr.addr           = pick_r;
        wr.data.arrival   = pick_arr_r;
        wr.data.burst     = pick_burst_r;
        wr.data.prio      = best_r;
        wr.data.remaining = pick_rem_r - 16'd1;
      end
      default: begin
        wr = '0;
      end
    endcase
  end

  assign cfg_ch.ready = 1'b1;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      time_r      <= '0;
      done_cnt_r  <= '0;
      pcount_r    <= CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        pcount_r <= cfg_ch.data;
      end
      // Load a new result, or drop the old one once its transfer completes
      if ((state_r == ST_WRITE) && adv) begin
        time_r      <= time_inc;
        out_valid_r <= 1'b1;
        if (fin && (done_cnt_r != '1)) begin
          done_cnt_r <= done_cnt_r + CNT_W'(1);
        end
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Scan and result payload
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        idx_r    <= '0;
        found_r  <= 1'b0;
        nz_cnt_r <= '0;
      end
      ST_SCAN: begin
        idx_r <= idx_r + IDX_W'(1);
        if (rd_data.remaining != 16'd0) begin
          nz_cnt_r <= nz_cnt_r + CNT_W'(1);
        end
        if (take) begin
          found_r      <= 1'b1;
          best_r       <= rd_data.prio;
          pick_r       <= idx_r;
          pick_arr_r   <= rd_data.arrival;
          pick_burst_r <= rd_data.burst;
          pick_rem_r   <= rd_data.remaining;
        end
      end
      ST_WRITE: begin
        if (adv) begin
          out_ran_r  <= found_r;
          out_pid_r  <= found_r ? 4'(pick_r) : 4'd0;
          out_fin_r  <= fin;
          out_tat_r  <= fin ? tat : 32'd0;
          out_wt_r   <= fin ? wt : 32'd0;
          out_all_r  <= all_done;
          out_time_r <= time_inc;
        end
      end
      default: begin
        idx_r <= idx_r;
      end
    endcase
  end

  // Drive result channel
  assign out_ch.valid        = out_valid_r;
  assign out_ch.ran          = out_ran_r;
  assign out_ch.process_id   = out_pid_r;
  assign out_ch.finished     = out_fin_r;
  assign out_ch.turnaround   = out_tat_r;
  assign out_ch.waiting      = out_wt_r;
  assign out_ch.all_done     = out_all_r;
  assign out_ch.current_time = out_time_r;

endmodule

// ===== src/pps_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_table
// Process table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pps_table (
  input  logic                  clk,
  input  pps_pkg::tbl_wr_t      wr,
  input  logic [pps_pkg::IDX_W-1:0] rd_addr,
  output pps_pkg::entry_t       rd_data
);
  import pps_pkg::*;

  entry_t mem [MAX_PROCESSES];

  // Write the requested entry
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== tb/pps_sched_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_sched_checker
// Watches the item, result and register channels of the priority scheduler.
// Keeps its own process table, time and slot count, works out the run report
// of every tick transfer and compares each result transfer field by field
// against the oldest pending report.
// ----------------------------------------------------------------------------
module pps_sched_checker (
  input  logic        clk,
  input  logic        rst_n,
  pps_in_if           in_ch,
  pps_out_if          out_ch,
  pps_cfg_if          cfg_ch,
  output int unsigned fail_count,
  output int unsigned backlog
);
  import pps_pkg::*;

  typedef struct packed {
    logic        ran;
    logic [3:0]  pid;
    logic        finished;
    logic [31:0] tat;
    logic [31:0] wt;
    logic        all_done;
    logic [31:0] now;
  } run_report_t;

  // Shadow process table and scheduler state
  logic [15:0] arrival_tbl   [MAX_PROCESSES];
  logic [15:0] burst_tbl     [MAX_PROCESSES];
  logic [7:0]  prio_tbl      [MAX_PROCESSES];
  logic [15:0] remaining_tbl [MAX_PROCESSES];
  logic [31:0] now_time;
  logic [4:0]  slot_limit;
  int unsigned errors;

  run_report_t expected_runs [$];

  initial begin
    errors     = 0;
    fail_count = 0;
    backlog    = 0;
    now_time   = '0;
    slot_limit = 5'd1;
    for (int i = 0; i < MAX_PROCESSES; i++) begin
      arrival_tbl[i]   = '0;
      burst_tbl[i]     = '0;
      prio_tbl[i]      = '0;
      remaining_tbl[i] = '0;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
      errors++;
    end
  endtask

  always @(posedge clk) begin : predict
    logic        hit;
    logic [3:0]  pick;
    logic [7:0]  best;
    int          used;
    run_report_t want;

    if (!rst_n) begin
      now_time   = '0;
      slot_limit = 5'd1;
      expected_runs.delete();
    end else begin
      // Compare a result transfer against the oldest pending report
      if (out_ch.valid && out_ch.ready) begin
        if (expected_runs.size() == 0) begin
          $display("%0t: result transfer with no tick pending, expected none, actual time %0h",
                   $time, out_ch.current_time);
          errors++;
        end else begin
          want = expected_runs.pop_front();
          check_field("ran", 32'(want.ran), 32'(out_ch.ran));
          check_field("process_id", 32'(want.pid), 32'(out_ch.process_id));
          check_field("finished", 32'(want.finished), 32'(out_ch.finished));
          check_field("turnaround", want.tat, out_ch.turnaround);
          check_field("waiting", want.wt, out_ch.waiting);
          check_field("all_done", 32'(want.all_done), 32'(out_ch.all_done));
          check_field("current_time", want.now, out_ch.current_time);
        end
      end

      if (cfg_ch.valid && cfg_ch.ready)
        slot_limit = cfg_ch.data;

      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.op == OP_LOAD) begin
          // Load overwrites the slot and restarts its work
          arrival_tbl[in_ch.slot]   = in_ch.arrival_time;
          burst_tbl[in_ch.slot]     = in_ch.burst_time;
          prio_tbl[in_ch.slot]      = in_ch.priority_req;
          remaining_tbl[in_ch.slot] = in_ch.burst_time;
        end else begin
          used = (slot_limit > MAX_PROCESSES) ? MAX_PROCESSES : int'(slot_limit);
          hit  = 1'b0;
          pick = '0;
          best = '0;
          // Pick the arrived slot with work and the smallest priority number
          for (int i = 0; i < used; i++) begin
            if ({16'd0, arrival_tbl[i]} <= now_time && remaining_tbl[i] != 0 &&
                (!hit || prio_tbl[i] < best)) begin
              hit  = 1'b1;
              best = prio_tbl[i];
              pick = 4'(i);
            end
          end
          now_time = now_time + 32'd1;
          want     = '0;
          want.now = now_time;
          // Run the chosen slot for one unit
          if (hit) begin
            want.ran            = 1'b1;
            want.pid            = pick;
            remaining_tbl[pick] = remaining_tbl[pick] - 16'd1;
            if (remaining_tbl[pick] == 0) begin
              want.finished = 1'b1;
              want.tat      = now_time - {16'd0, arrival_tbl[pick]};
              want.wt       = want.tat - {16'd0, burst_tbl[pick]};
            end
          end
          want.all_done = 1'b1;
          for (int i = 0; i < used; i++)
            if (remaining_tbl[i] != 0) want.all_done = 1'b0;
          expected_runs.push_back(want);
        end
      end
    end
    backlog    <= expected_runs.size();
    fail_count <= errors;
  end

endmodule

// ===== tb/tb_preemptive_priority_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_preemptive_priority_scheduler
// Drives load and tick items into the priority scheduler under several slot
// counts and handshake stall patterns; the checker beside the block predicts
// and compares every run report, and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_preemptive_priority_scheduler;
  import pps_pkg::*;

  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 190;
  localparam int STALL_LIMIT  = 2000;

  logic        clk;
  logic        rst_n;
  int unsigned mismatch_total;
  int unsigned runs_outstanding;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned stall_cycles;
  logic [31:0] ticks_sent;

  int unsigned count_plan [PHASES] = '{16, 1, 0, 31, 17, 5, 16, 2, 9};

  pps_in_if  in_ch ();
  pps_out_if out_ch ();
  pps_cfg_if cfg_ch ();

  preemptive_priority_scheduler dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  pps_sched_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (mismatch_total),
    .backlog    (runs_outstanding)
  );

  // Clock, 4 ns period
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Receiver stalls
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Present one item and hold it until the transfer
  task automatic send_item(input logic op, input logic [3:0] slot,
                           input logic [15:0] arr, input logic [15:0] bst,
                           input logic [7:0] pri);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.op           <= op;
    in_ch.slot         <= slot;
    in_ch.arrival_time <= arr;
    in_ch.burst_time   <= bst;
    in_ch.priority_req <= pri;
    do @(posedge clk); while (!in_ch.ready);
    if (op == OP_TICK) ticks_sent++;
  endtask

  // Drop valid and let every pending report and trailing load settle
  task automatic drain_pipeline();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (runs_outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_count(input logic [4:0] value);
    drain_pipeline();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [3:0]  slot;
    logic [15:0] arr;
    logic [15:0] bst;
    logic [7:0]  pri;
    int unsigned sel;

    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.op           = OP_LOAD;
    in_ch.slot         = '0;
    in_ch.arrival_time = '0;
    in_ch.burst_time   = '0;
    in_ch.priority_req = '0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.data        = '0;
    send_idle_pct      = 0;
    recv_idle_pct      = 0;
    stall_cycles       = 0;
    ticks_sent         = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Fill every slot: ties, zero burst, late arrival, field extremes
    for (int s = 0; s < MAX_PROCESSES; s++) begin
      case (s)
        0:       send_item(OP_LOAD, 4'(s), 16'd0, 16'd1, 8'd0);
        1:       send_item(OP_LOAD, 4'(s), 16'd0, 16'd3, 8'd5);
        2:       send_item(OP_LOAD, 4'(s), 16'd0, 16'd2, 8'd5);
        3:       send_item(OP_LOAD, 4'(s), 16'd0, 16'd0, 8'd0);
        4:       send_item(OP_LOAD, 4'(s), 16'd2, 16'd1, 8'd1);
        15:      send_item(OP_LOAD, 4'(s), 16'hFFFF, 16'hFFFF, 8'hFF);
        default: send_item(OP_LOAD, 4'(s), 16'h8000 + 16'(s), 16'd1, 8'h80 + 8'(s));
      endcase
    end
    // One slot in use out of reset
    send_item(OP_TICK, '0, '0, '0, '0);
    // Tie, preemption, completions, then idle
    write_count(5'd16);
    repeat (7) send_item(OP_TICK, 4'hF, 16'hFFFF, 16'hFFFF, 8'hFF);
    // Count above the table size and no slot in use
    write_count(5'd31);
    send_item(OP_TICK, '0, '0, '0, '0);
    write_count(5'd0);
    send_item(OP_TICK, '0, '0, '0, '0);

    for (int p = 0; p < PHASES; p++) begin
      write_count(5'(count_plan[p]));
      if (p < 3) begin
        send_idle_pct = 27;
        recv_idle_pct = 61;
      end else if (p < 6) begin
        send_idle_pct = 61;
        recv_idle_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 99) < 35) begin
          slot = 4'($urandom_range(0, 15));
          // Arrivals mostly near the current time
          sel = $urandom_range(0, 99);
          if (sel < 70)      arr = ticks_sent[15:0] + 16'($urandom_range(0, 6));
          else if (sel < 85) arr = ticks_sent[15:0] - 16'($urandom_range(0, 20));
          else if (sel < 95) arr = 16'($urandom);
          else               arr = 16'd0;
          sel = $urandom_range(0, 99);
          if (sel < 70)      bst = 16'($urandom_range(1, 4));
          else if (sel < 88) bst = 16'($urandom_range(5, 30));
          else if (sel < 95) bst = 16'd0;
          else               bst = 16'($urandom);
          pri = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 7)) : 8'($urandom);
          send_item(OP_LOAD, slot, arr, bst, pri);
        end else begin
          // Tick with junk in the unused fields
          send_item(OP_TICK, 4'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
        end
      end
    end

    drain_pipeline();
    repeat (40) @(negedge clk);
    if (mismatch_total == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/pps_pkg.sv
src/pps_in_if.sv
src/pps_out_if.sv
src/pps_cfg_if.sv
src/pps_table.sv
src/preemptive_priority_scheduler.sv
tb/pps_sched_checker.sv
tb/tb_preemptive_priority_scheduler.sv
